FILE: rtl/msort_pkg.sv
// Shared types for the merge sorter block.
// No dependencies; imported by msort_cell, merge_sorter_top, merge_sorter_checker and tb_merge_sorter_top.
`timescale 1ns / 1ps

package msort_pkg;

  // Broadcast control from the top level to every cell in the chain
  typedef struct packed {
    logic insert;   // place the broadcast value into the ordered chain
    logic shift;    // move every entry one cell towards cell 0
  } cell_ctrl_t;

  // Width of the value field on both streams
  localparam int unsigned FieldWidth = 32;

endpackage

FILE: rtl/msort_cell.sv
// One cell of the sorting chain: holds a single entry and its valid bit.
// Depends on msort_pkg for the control struct.
`timescale 1ns / 1ps

module msort_cell import msort_pkg::*; #(
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cell_ctrl_t            ctrl,
  input  logic [DATA_WIDTH-1:0] new_val,     // value being inserted
  input  logic [DATA_WIDTH-1:0] prev_val,    // neighbour towards cell 0
  input  logic                  prev_valid,
  input  logic                  prev_lt,
  input  logic [DATA_WIDTH-1:0] next_val,    // neighbour away from cell 0
  input  logic                  next_valid,
  output logic [DATA_WIDTH-1:0] val,
  output logic                  valid,
  output logic                  lt           // new value belongs at or before this cell
);

  logic [DATA_WIDTH-1:0] val_r, val_nxt;
  logic                  valid_r, valid_nxt;

  // empty cells act as +infinity
  assign lt = !valid_r || ($signed(new_val) < $signed(val_r));

  always_comb begin
    val_nxt   = val_r;
    valid_nxt = valid_r;
    if (ctrl.shift) begin
      val_nxt   = next_val;
      valid_nxt = next_valid;
    end else if (ctrl.insert && lt) begin
      if (prev_lt) begin
        val_nxt   = prev_val;
        valid_nxt = prev_valid;
      end else begin
        val_nxt   = new_val;
        valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val   = val_r;
  assign valid = valid_r;

endmodule

FILE: rtl/merge_sorter_top.sv
// Top level of the merge sorter: chain of sorting cells, drain control, output register.
// Depends on msort_pkg and msort_cell.
`timescale 1ns / 1ps
//
//  channel | direction | tdata                 | tlast        | tuser
//  --------+-----------+-----------------------+--------------+---------
//  in_     | slave     | [31:0] value          | last         | -
//  out_    | master    | [31:0] sorted_value   | end_of_list  | [0] overflow
//
//  Each item is placed into the ordered chain of cells as it arrives, so the list
//  is sorted when the last item lands. Draining gives one result per cycle from
//  cell 0 as the chain shifts down, whenever the output is not stalled.
//  in_tready is low while the chain drains; a stalled output holds the chain.
//  Reset (synchronous, active low) clears every cell's valid bit at once.
//  Items arriving with all MAX_ITEMS cells full are dropped and the list is flagged.

module merge_sorter_top import msort_pkg::*; #(
  parameter int unsigned MAX_ITEMS  = 64,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [FieldWidth-1:0] in_tdata,    // [31:0] value
  input  logic                  in_tlast,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [FieldWidth-1:0] out_tdata,   // [31:0] sorted_value
  output logic                  out_tlast,
  output logic [0:0]            out_tuser    // [0] overflow
);

  localparam logic ST_LOAD  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic                  state_r, state_nxt;
  logic                  dropped_r, dropped_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [FieldWidth-1:0] out_data_r, out_data_nxt;
  logic                  out_last_r, out_last_nxt;
  logic                  out_ovf_r, out_ovf_nxt;

  logic [DATA_WIDTH-1:0] val_ext [MAX_ITEMS+2];
  logic [MAX_ITEMS+1:0]  valid_ext;
  logic [MAX_ITEMS:0]    lt_ext;
  logic [MAX_ITEMS-1:0]  cell_valid;
  logic [DATA_WIDTH-1:0] new_val;
  logic                  in_acc, full, take;
  cell_ctrl_t            ctrl;

  // value resized to the storage width
  generate
    if (DATA_WIDTH <= FieldWidth) begin : g_in_trunc
      assign new_val = in_tdata[DATA_WIDTH-1:0];
    end else begin : g_in_ext
      assign new_val = {{(DATA_WIDTH-FieldWidth){1'b0}}, in_tdata};
    end
  endgenerate

  // padding at both ends of the chain
  assign val_ext[0]             = '0;
  assign valid_ext[0]           = 1'b0;
  assign lt_ext[0]              = 1'b0;
  assign val_ext[MAX_ITEMS+1]   = '0;
  assign valid_ext[MAX_ITEMS+1] = 1'b0;

  generate
    for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
      msort_cell #(
        .DATA_WIDTH (DATA_WIDTH)
      ) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl),
        .new_val    (new_val),
        .prev_val   (val_ext[i]),
        .prev_valid (valid_ext[i]),
        .prev_lt    (lt_ext[i]),
        .next_val   (val_ext[i+2]),
        .next_valid (valid_ext[i+2]),
        .val        (val_ext[i+1]),
        .valid      (valid_ext[i+1]),
        .lt         (lt_ext[i+1])
      );
    end
  endgenerate

  assign cell_valid = valid_ext[MAX_ITEMS:1];
  assign full       = cell_valid[MAX_ITEMS-1];

  assign in_tready = (state_r == ST_LOAD);
  assign in_acc    = in_tvalid && in_tready;
  assign take      = (state_r == ST_DRAIN) && (!out_valid_r || out_tready);

  assign ctrl.insert = in_acc && !full;
  assign ctrl.shift  = take;

  always_comb begin
    state_nxt     = state_r;
    dropped_nxt   = dropped_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    if (in_acc) begin
      if (full) begin
        dropped_nxt = 1'b1;
      end
      if (in_tlast) begin
        state_nxt = ST_DRAIN;
      end
    end
    if (take) begin
      out_valid_nxt = 1'b1;
      if (DATA_WIDTH >= FieldWidth) begin
        out_data_nxt = val_ext[1][FieldWidth-1:0];
      end else begin
        out_data_nxt = FieldWidth'(val_ext[1]);
      end
      out_last_nxt = !cell_valid[1];
      out_ovf_nxt  = dropped_r;
      if (!cell_valid[1]) begin
        state_nxt   = ST_LOAD;
        dropped_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      dropped_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      dropped_r   <= dropped_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    out_last_r <= out_last_nxt;
    out_ovf_r  <= out_ovf_nxt;
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tlast    = out_last_r;
  assign out_tuser[0] = out_ovf_r;

`ifndef ASSERT_OFF
  // occupied cells always form an unbroken run from cell 0
  a_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
    ((cell_valid >> 1) & ~cell_valid) == '0)
    else $error("chain has a gap in its occupied cells");

  // a closing transaction always leaves something to drain
  a_drain_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_tlast) |=> (state_r == ST_DRAIN) && cell_valid[0])
    else $error("drain started with an empty chain");

  // leaving drain means the final result has just been registered
  a_drain_end: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(state_r == ST_DRAIN) |-> (out_valid_r && out_last_r))
    else $error("drain ended without the end-of-list result");

  // the overflow flag does not rise while draining
  a_no_insert: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |=> $stable(dropped_r) || !dropped_r)
    else $error("overflow flag changed during drain");
`endif

endmodule

FILE: test/merge_sorter_checker.sv
// Checker for merge_sorter_top: watches both streams, predicts the sorted lists and compares.
// Depends on msort_pkg; instantiated beside the block by tb_merge_sorter_top.
`timescale 1ns / 1ps

module merge_sorter_checker import msort_pkg::*; #(
  parameter int unsigned MAX_ITEMS = 64
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [FieldWidth-1:0] in_tdata,    // [31:0] value
  input  logic                  in_tlast,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [FieldWidth-1:0] out_tdata,   // [31:0] sorted_value
  input  logic                  out_tlast,
  input  logic [0:0]            out_tuser,   // [0] overflow
  output int                    mismatches,
  output int                    outstanding
);

  typedef struct packed {
    logic signed [FieldWidth-1:0] value;
    logic                         end_of_list;
    logic                         overflow;
  } sorted_item_t;

  logic signed [FieldWidth-1:0] loaded_list[$];
  logic                         list_dropped;
  sorted_item_t                 sorted_expect_q[$];

  initial begin
    mismatches   = 0;
    outstanding  = 0;
    list_dropped = 1'b0;
  end

  // Order the list held so far and queue one expected result per stored element.
  task automatic sort_loaded_list();
    logic signed [FieldWidth-1:0] ordered[$];
    logic signed [FieldWidth-1:0] v;
    sorted_item_t                 item;
    int                           j;
    ordered = loaded_list;
    for (int i = 1; i < ordered.size(); i++) begin
      v = ordered[i];
      j = i - 1;
      while (j >= 0 && ordered[j] > v) begin
        ordered[j + 1] = ordered[j];
        j--;
      end
      ordered[j + 1] = v;
    end
    for (int i = 0; i < ordered.size(); i++) begin
      item.value       = ordered[i];
      item.end_of_list = (i == ordered.size() - 1);
      item.overflow    = list_dropped;
      sorted_expect_q  = {sorted_expect_q, item};
    end
    loaded_list.delete();
    list_dropped = 1'b0;
  endtask

  task automatic check_result();
    sorted_item_t exp_item;
    if (sorted_expect_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("[%0t] unexpected result: value=%0d last=%b overflow=%b",
                 $realtime, $signed(out_tdata), out_tlast, out_tuser[0]);
    end else begin
      exp_item = sorted_expect_q.pop_front();
      if (out_tdata !== exp_item.value || out_tlast !== exp_item.end_of_list ||
          out_tuser[0] !== exp_item.overflow) begin
        mismatches++;
        if (mismatches <= 10)
          $display("[%0t] expected value=%0d last=%b ovf=%b, got value=%0d last=%b ovf=%b",
                   $realtime, exp_item.value, exp_item.end_of_list, exp_item.overflow,
                   $signed(out_tdata), out_tlast, out_tuser[0]);
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        if (loaded_list.size() < MAX_ITEMS)
          loaded_list = {loaded_list, in_tdata};
        else
          list_dropped = 1'b1;
        if (in_tlast)
          sort_loaded_list();
      end
      if (out_tvalid && out_tready)
        check_result();
    end
    outstanding <= sorted_expect_q.size();
  end

endmodule

FILE: test/tb_merge_sorter_top.sv
// Testbench top for merge_sorter_top: clock, reset, list stimulus and the verdict.
// Depends on msort_pkg, merge_sorter_top and merge_sorter_checker.
`timescale 1ns / 1ps

module tb_merge_sorter_top import msort_pkg::*; ();

  localparam int unsigned CAPACITY   = 64;
  localparam int          CYCLE_CAP  = 400000;
  localparam int          DRAIN_WAIT = 2 * CAPACITY + 16;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [FieldWidth-1:0] in_tdata;
  logic                  in_tlast;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [FieldWidth-1:0] out_tdata;
  logic                  out_tlast;
  logic [0:0]            out_tuser;
  int                    mismatches;
  int                    outstanding;
  int                    tx_idle_pct;
  int                    rx_idle_pct;
  int                    cycles;

  merge_sorter_top #(.MAX_ITEMS(CAPACITY), .DATA_WIDTH(32)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  merge_sorter_checker #(.MAX_ITEMS(CAPACITY)) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_CAP) begin
      @(posedge clk);
      cycles++;
    end
    $display("** merge_sorter_top: FAILED **");
    $finish;
  end

  // Holds the transaction until accepted; the gap before it is random.
  task automatic send_item(input logic [FieldWidth-1:0] value, input logic last);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready)
      @(posedge clk);
  endtask

  // Mostly full-range values, with extremes and a narrow band for duplicates.
  function automatic logic [FieldWidth-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2, 3:    return 32'hFFFF_FFFC + $urandom_range(0, 7);
      default: return $urandom();
    endcase
  endfunction

  task automatic send_list(input int len);
    for (int i = 0; i < len; i++)
      send_item(pick_value(), i == len - 1);
  endtask

  initial begin
    int phase_items;
    int len;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tlast    = 1'b0;
    out_tready  = 1'b0;
    tx_idle_pct = 17;
    rx_idle_pct = 74;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // one-element list holding the largest value
    send_item(32'h7FFF_FFFF, 1'b1);
    // extremes, zero, duplicates of both ends
    send_item(32'h7FFF_FFFF, 1'b0);
    send_item(32'h8000_0000, 1'b0);
    send_item(32'h0000_0000, 1'b0);
    send_item(32'hFFFF_FFFF, 1'b0);
    send_item(32'h0000_0001, 1'b0);
    send_item(32'h7FFF_FFFF, 1'b0);
    send_item(32'h8000_0000, 1'b0);
    send_item(32'h0000_0005, 1'b0);
    send_item(32'h0000_0005, 1'b1);
    // strictly descending, then already ascending
    for (int i = 0; i < 6; i++)
      send_item(32'(50 - 10 * i), i == 5);
    for (int i = 0; i < 4; i++)
      send_item(32'hFFFF_FFFE + i, i == 3);
    // two equal values only
    send_item(32'hAAAA_5555, 1'b0);
    send_item(32'hAAAA_5555, 1'b1);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct = 17;
          rx_idle_pct = 74;
        end
        1: begin
          tx_idle_pct = 74;
          rx_idle_pct = 17;
        end
        default: begin
          tx_idle_pct = 0;
          rx_idle_pct = 0;
        end
      endcase
      phase_items = 0;
      while (phase_items < 100) begin
        case ($urandom_range(0, 9))
          0:       len = CAPACITY + $urandom_range(0, 6);
          1:       len = $urandom_range(30, CAPACITY);
          default: len = $urandom_range(1, 10);
        endcase
        // the closing transaction itself is dropped on the first list of each phase
        if (phase_items == 0)
          len = CAPACITY + 1;
        send_list(len);
        phase_items += len;
      end
    end
    in_tvalid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0 && outstanding == 0)
      $display("** merge_sorter_top: PASSED **");
    else
      $display("** merge_sorter_top: FAILED **");
    $finish;
  end

endmodule
